/* rtl/pi_auto_exposure_gain_macros.svh */
// assertion macros for the auto exposure and gain controller
// expects i_clk and i_rst_n in the scope where a macro is used
`ifndef PI_AUTO_EXPOSURE_GAIN_MACROS_SVH
`define PI_AUTO_EXPOSURE_GAIN_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked out of reset
`define PIAEG_ASSERT_IMP(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("piaeg: same-cycle check failed");

// next-cycle implication, checked out of reset
`define PIAEG_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("piaeg: next-cycle check failed");

`else

`define PIAEG_ASSERT_IMP(lbl, pre, post)
`define PIAEG_ASSERT_NEXT(lbl, pre, post)

`endif

`endif

/* rtl/piaeg_pkg.sv */
// shared types, constants and microprogram for the auto exposure and gain controller
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package piaeg_pkg;

    // datapath widths
    localparam int ERR_W     = 17;   // signed target minus brightness
    localparam int A_W       = 34;   // wide multiplier operand, adjustment, factor
    localparam int B_W       = 17;   // narrow multiplier operand
    localparam int P_W       = 51;   // product
    localparam int V_W       = 32;   // scaled value before clamping
    localparam int INT_SUM_W = 18;   // integral plus step before clamping
    localparam int CFG_IDX_W = 3;
    localparam int STEP_W    = 4;
    localparam int MODE_W    = 3;

    // fixed-point constants
    localparam logic signed [A_W-1:0] ONE_Q20 = A_W'(1048576);
    localparam logic signed [P_W-1:0] BIAS16  = P_W'(65535);
    localparam logic signed [P_W-1:0] BIAS20  = P_W'(1048575);
    localparam logic [B_W-1:0] STEP_FAST = B_W'(9830);   // 0.15 in q0.16
    localparam logic [B_W-1:0] STEP_MID  = B_W'(6554);   // 0.10
    localparam logic [B_W-1:0] STEP_SLOW = B_W'(3277);   // 0.05
    localparam logic signed [INT_SUM_W-1:0] INT_LIMIT     = INT_SUM_W'(12800);
    localparam logic signed [INT_SUM_W-1:0] INT_LIMIT_NEG = -INT_SUM_W'(12800);
    localparam logic [15:0] EXP_KNEE   = 16'd10000;
    localparam logic [15:0] GAIN_KNEE  = 16'd16384;  // 4.0
    localparam logic [15:0] GAIN_DROP  = 16'd6144;   // 1.5
    localparam logic [15:0] GAIN_FLOOR = 16'd4096;   // 1.0
    localparam logic [15:0] BASE_OFFSET = 16'd256;   // 1.0 in q8.8

    // state and register reset values
    localparam logic [15:0] RST_EXPOSURE  = 16'd5000;
    localparam logic [15:0] RST_GAIN      = 16'd8192;
    localparam logic [15:0] RST_TARGET    = 16'd20480;
    localparam logic [15:0] RST_TOLERANCE = 16'd2048;
    localparam logic [15:0] RST_KP        = 16'd2048;
    localparam logic [15:0] RST_KI        = 16'd410;
    localparam logic [15:0] RST_HI_GAIN   = 16'd24576;
    localparam logic [15:0] RST_MIN_EXP   = 16'd100;
    localparam logic [15:0] RST_MAX_EXP   = 16'd20000;
    localparam logic [15:0] RST_MAX_GAIN  = 16'd32768;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TARGET    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KP        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KI        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HI_GAIN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_EXP   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_EXP   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_GAIN  = 3'd7;

    typedef struct packed {
        logic [15:0] target;
        logic [15:0] tolerance;
        logic [15:0] kp;
        logic [15:0] ki;
        logic [15:0] hi_gain_thr;
        logic [15:0] min_exp;
        logic [15:0] max_exp;
        logic [15:0] gain_ceil;
    } t_cfg;

    // multiplier operand selects
    localparam logic [2:0] MUL_NONE       = 3'd0;
    localparam logic [2:0] MUL_KP_ERR     = 3'd1;
    localparam logic [2:0] MUL_KI_INT     = 3'd2;
    localparam logic [2:0] MUL_ERR_STEP   = 3'd3;
    localparam logic [2:0] MUL_ADJ_C      = 3'd4;
    localparam logic [2:0] MUL_OLD_FACTOR = 3'd5;

    // datapath operations
    localparam logic [3:0] OP_NOP      = 4'd0;
    localparam logic [3:0] OP_CAPTURE  = 4'd1;
    localparam logic [3:0] OP_BAND     = 4'd2;
    localparam logic [3:0] OP_ADJ_LOAD = 4'd3;
    localparam logic [3:0] OP_ADJ_ADD  = 4'd4;
    localparam logic [3:0] OP_PLAN     = 4'd5;
    localparam logic [3:0] OP_FACTOR   = 4'd6;
    localparam logic [3:0] OP_APPLY    = 4'd7;
    localparam logic [3:0] OP_FLAG     = 4'd8;
    localparam logic [3:0] OP_OUT      = 4'd9;

    // sequencer conditions
    localparam logic [2:0] C_NEXT     = 3'd0;
    localparam logic [2:0] C_WAIT_IN  = 3'd1;   // hold until a transaction arrives, then jump
    localparam logic [2:0] C_WAIT_OUT = 3'd2;   // hold while the result slot is blocked, then jump
    localparam logic [2:0] C_IN_BAND  = 3'd3;
    localparam logic [2:0] C_NO_PLAN  = 3'd4;

    // program steps
    localparam logic [STEP_W-1:0] S_IDLE   = 4'd0;
    localparam logic [STEP_W-1:0] S_BAND   = 4'd1;
    localparam logic [STEP_W-1:0] S_KP     = 4'd2;
    localparam logic [STEP_W-1:0] S_KI     = 4'd3;
    localparam logic [STEP_W-1:0] S_ISTEP  = 4'd4;
    localparam logic [STEP_W-1:0] S_PLAN   = 4'd5;
    localparam logic [STEP_W-1:0] S_SCALE  = 4'd6;
    localparam logic [STEP_W-1:0] S_FACTOR = 4'd7;
    localparam logic [STEP_W-1:0] S_MULOLD = 4'd8;
    localparam logic [STEP_W-1:0] S_APPLY  = 4'd9;
    localparam logic [STEP_W-1:0] S_FLAG   = 4'd10;
    localparam logic [STEP_W-1:0] S_OUT    = 4'd11;

    // update plans
    localparam logic [MODE_W-1:0] M_NONE       = 3'd0;
    localparam logic [MODE_W-1:0] M_EXP_KNEE   = 3'd1;  // dark, exposure up to the knee
    localparam logic [MODE_W-1:0] M_GAIN_KNEE  = 3'd2;  // dark, gain up to 4.0
    localparam logic [MODE_W-1:0] M_EXP_MID    = 3'd3;  // dark, exposure up to max
    localparam logic [MODE_W-1:0] M_GAIN_TOP   = 3'd4;  // dark, gain up to max gain
    localparam logic [MODE_W-1:0] M_GAIN_FLOOR = 3'd5;  // bright, gain down to 1.0
    localparam logic [MODE_W-1:0] M_EXP_FAST   = 3'd6;  // bright, exposure down

    typedef struct packed {
        logic [2:0]        mul_sel;
        logic [3:0]        op;
        logic [2:0]        cond;
        logic [STEP_W-1:0] tgt;
    } t_uword;

    typedef struct packed {
        logic [2:0] mul_sel;
        logic [3:0] op;
        logic       fire;
    } t_dp_ctl;

    typedef struct packed {
        logic in_band;
        logic no_plan;
        logic out_busy;
    } t_dp_stat;

    function automatic t_uword uprog(input logic [STEP_W-1:0] step);
        t_uword w;
        unique case (step)
            S_IDLE:   w = '{mul_sel: MUL_NONE,       op: OP_CAPTURE,  cond: C_WAIT_IN,  tgt: S_BAND};
            S_BAND:   w = '{mul_sel: MUL_NONE,       op: OP_BAND,     cond: C_IN_BAND,  tgt: S_OUT};
            S_KP:     w = '{mul_sel: MUL_KP_ERR,     op: OP_NOP,      cond: C_NEXT,     tgt: S_IDLE};
            S_KI:     w = '{mul_sel: MUL_KI_INT,     op: OP_ADJ_LOAD, cond: C_NEXT,     tgt: S_IDLE};
            S_ISTEP:  w = '{mul_sel: MUL_ERR_STEP,   op: OP_ADJ_ADD,  cond: C_NEXT,     tgt: S_IDLE};
            S_PLAN:   w = '{mul_sel: MUL_NONE,       op: OP_PLAN,     cond: C_NEXT,     tgt: S_IDLE};
            S_SCALE:  w = '{mul_sel: MUL_ADJ_C,      op: OP_NOP,      cond: C_NO_PLAN,  tgt: S_FLAG};
            S_FACTOR: w = '{mul_sel: MUL_NONE,       op: OP_FACTOR,   cond: C_NEXT,     tgt: S_IDLE};
            S_MULOLD: w = '{mul_sel: MUL_OLD_FACTOR, op: OP_NOP,      cond: C_NEXT,     tgt: S_IDLE};
            S_APPLY:  w = '{mul_sel: MUL_NONE,       op: OP_APPLY,    cond: C_NEXT,     tgt: S_IDLE};
            S_FLAG:   w = '{mul_sel: MUL_NONE,       op: OP_FLAG,     cond: C_NEXT,     tgt: S_IDLE};
            S_OUT:    w = '{mul_sel: MUL_NONE,       op: OP_OUT,      cond: C_WAIT_OUT, tgt: S_IDLE};
            default:  w = '{mul_sel: MUL_NONE,       op: OP_NOP,      cond: C_WAIT_OUT, tgt: S_IDLE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

/* rtl/piaeg_cfg.sv */
// configuration register bank for the auto exposure and gain controller
// depends on piaeg_pkg
`timescale 1ns / 1ps
`default_nettype none

module piaeg_cfg (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire [piaeg_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire [15:0]                       i_cfg_data,
    output piaeg_pkg::t_cfg                  o_cfg
);
    import piaeg_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target      <= RST_TARGET;
            r_cfg.tolerance   <= RST_TOLERANCE;
            r_cfg.kp          <= RST_KP;
            r_cfg.ki          <= RST_KI;
            r_cfg.hi_gain_thr <= RST_HI_GAIN;
            r_cfg.min_exp     <= RST_MIN_EXP;
            r_cfg.max_exp     <= RST_MAX_EXP;
            r_cfg.gain_ceil   <= RST_MAX_GAIN;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_TARGET:    r_cfg.target      <= i_cfg_data;
                REG_TOLERANCE: r_cfg.tolerance   <= i_cfg_data;
                REG_KP:        r_cfg.kp          <= i_cfg_data;
                REG_KI:        r_cfg.ki          <= i_cfg_data;
                REG_HI_GAIN:   r_cfg.hi_gain_thr <= i_cfg_data;
                REG_MIN_EXP:   r_cfg.min_exp     <= i_cfg_data;
                REG_MAX_EXP:   r_cfg.max_exp     <= i_cfg_data;
                REG_MAX_GAIN:  r_cfg.gain_ceil   <= i_cfg_data;
                default:       r_cfg.target      <= r_cfg.target;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

/* rtl/piaeg_seq.sv */
// microcode sequencer: step counter, program rom lookup and jump logic
// depends on piaeg_pkg
`timescale 1ns / 1ps
`default_nettype none

module piaeg_seq (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_in_valid,
    input  piaeg_pkg::t_dp_stat    i_stat,
    output piaeg_pkg::t_dp_ctl     o_ctl,
    output logic                   o_busy
);
    import piaeg_pkg::*;

    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    t_uword            w_uw;
    logic              w_hold;
    logic              w_take;

    assign w_uw = uprog(r_step);

    always_comb begin
        w_hold = ((w_uw.cond == C_WAIT_IN) && !i_in_valid) ||
                 ((w_uw.cond == C_WAIT_OUT) && i_stat.out_busy);
        unique case (w_uw.cond)
            C_NEXT:     w_take = 1'b0;
            C_WAIT_IN:  w_take = 1'b1;
            C_WAIT_OUT: w_take = 1'b1;
            C_IN_BAND:  w_take = i_stat.in_band;
            C_NO_PLAN:  w_take = i_stat.no_plan;
            default:    w_take = 1'b0;
        endcase
        priority if (w_hold) begin
            n_step = r_step;
        end else if (w_take) begin
            n_step = w_uw.tgt;
        end else begin
            n_step = r_step + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_ctl.mul_sel = w_uw.mul_sel;
    assign o_ctl.op      = w_uw.op;
    assign o_ctl.fire    = !w_hold;
    assign o_busy        = (r_step != S_IDLE);

endmodule

`default_nettype wire

/* rtl/piaeg_dp.sv */
// datapath: shared multiplier, pi accumulator, integral, exposure and gain state, result register
// depends on piaeg_pkg, driven by piaeg_seq
`timescale 1ns / 1ps
`default_nettype none

module piaeg_dp (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  piaeg_pkg::t_cfg        i_cfg,
    input  piaeg_pkg::t_dp_ctl     i_ctl,
    input  wire [15:0]             i_mean_brightness,
    input  wire                    i_out_stall,
    output piaeg_pkg::t_dp_stat    o_stat,
    output logic                   o_out_valid,
    output logic [15:0]            o_exposure_time,
    output logic [15:0]            o_analogue_gain,
    output logic                   o_noise_reduction,
    output logic                   o_adjusted
);
    import piaeg_pkg::*;

    function automatic logic signed [V_W-1:0] ext32(input logic [15:0] x);
        return {{(V_W-16){1'b0}}, x};
    endfunction

    function automatic logic [15:0] sat_u16(input logic signed [V_W-1:0] v);
        logic [15:0] res;
        priority if (v < 0) begin
            res = 16'd0;
        end else if (v > ext32(16'hFFFF)) begin
            res = 16'hFFFF;
        end else begin
            res = v[15:0];
        end
        return res;
    endfunction

    // state
    logic [15:0]              r_exposure;
    logic [15:0]              r_gain;
    logic signed [15:0]       r_integ;
    logic                     r_noise;

    // working registers
    logic signed [ERR_W-1:0]  r_err;
    logic [15:0]              r_bright;
    logic                     r_adjusted;
    logic signed [A_W-1:0]    r_adj;
    logic signed [A_W-1:0]    r_factor;
    logic signed [P_W-1:0]    r_prod;
    logic [MODE_W-1:0]        r_mode;

    // result register
    logic                     r_out_valid;
    logic [15:0]              r_out_exp;
    logic [15:0]              r_out_gain;
    logic                     r_out_noise;
    logic                     r_out_adj;

    logic signed [A_W-1:0]    w_a;
    logic signed [B_W-1:0]    w_b;
    logic [B_W-1:0]           w_c;
    logic [15:0]              w_old;
    logic signed [P_W-1:0]    w_prod;
    logic signed [P_W-1:0]    w_bias16, w_bias20;
    logic signed [P_W-1:0]    w_sum16, w_sum20;
    logic signed [P_W-1:0]    w_q16, w_q20;
    logic [ERR_W-1:0]         w_mag;
    logic signed [INT_SUM_W-1:0] w_isum;
    logic signed [15:0]       w_integ_new;
    logic [21:0]              w_lhs, w_b21, w_b19;
    logic [16:0]              w_base;
    logic                     w_dark, w_light;
    logic [MODE_W-1:0]        w_mode;
    logic signed [V_W-1:0]    w_v;
    logic signed [V_W-1:0]    w_ehi, w_et, w_eclamp;
    logic signed [V_W-1:0]    w_g;
    logic [15:0]              w_exp_new, w_gain_new;
    logic                     w_is_exp;

    // step constant and old value follow the plan
    always_comb begin
        unique case (r_mode)
            M_EXP_KNEE, M_EXP_FAST: w_c = STEP_FAST;
            M_GAIN_TOP:             w_c = STEP_SLOW;
            default:                w_c = STEP_MID;
        endcase
    end

    assign w_is_exp = (r_mode == M_EXP_KNEE) || (r_mode == M_EXP_MID) ||
                      (r_mode == M_EXP_FAST);
    assign w_old    = w_is_exp ? r_exposure : r_gain;

    // operand select for the shared multiplier
    always_comb begin
        unique case (i_ctl.mul_sel)
            MUL_KP_ERR: begin
                w_a = {{(A_W-ERR_W){r_err[ERR_W-1]}}, r_err};
                w_b = {1'b0, i_cfg.kp};
            end
            MUL_KI_INT: begin
                w_a = {{(A_W-16){r_integ[15]}}, r_integ};
                w_b = {1'b0, i_cfg.ki};
            end
            MUL_ERR_STEP: begin
                w_a = {{(A_W-ERR_W){r_err[ERR_W-1]}}, r_err};
                w_b = STEP_MID;
            end
            MUL_ADJ_C: begin
                w_a = r_adj;
                w_b = w_c;
            end
            MUL_OLD_FACTOR: begin
                w_a = r_factor;
                w_b = {1'b0, w_old};
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
    end

    assign w_prod = w_a * w_b;

    // quotients by 2^16 and 2^20, truncated toward zero
    assign w_bias16 = r_prod[P_W-1] ? BIAS16 : '0;
    assign w_bias20 = r_prod[P_W-1] ? BIAS20 : '0;
    assign w_sum16  = r_prod + w_bias16;
    assign w_sum20  = r_prod + w_bias20;
    assign w_q16    = w_sum16 >>> 16;
    assign w_q20    = w_sum20 >>> 20;

    // dead band
    assign w_mag = r_err[ERR_W-1] ? (~r_err + 1'b1) : r_err;

    // integral step and clamp
    assign w_isum = {{(INT_SUM_W-16){r_integ[15]}}, r_integ} + w_q16[INT_SUM_W-1:0];
    always_comb begin
        priority if (w_isum > INT_LIMIT) begin
            w_integ_new = INT_LIMIT[15:0];
        end else if (w_isum < INT_LIMIT_NEG) begin
            w_integ_new = INT_LIMIT_NEG[15:0];
        end else begin
            w_integ_new = w_isum[15:0];
        end
    end

    // brightness ratio against 1.05 and 0.95, exact in integers
    assign w_lhs   = 22'({i_cfg.target, 4'b0}) + 22'({i_cfg.target, 2'b0});
    assign w_base  = {1'b0, r_bright} + {1'b0, BASE_OFFSET};
    assign w_b21   = 22'({w_base, 4'b0}) + 22'({w_base, 2'b0}) + 22'(w_base);
    assign w_b19   = 22'({w_base, 4'b0}) + 22'({w_base, 1'b0}) + 22'(w_base);
    assign w_dark  = w_lhs > w_b21;
    assign w_light = w_lhs < w_b19;

    always_comb begin
        priority if (w_dark) begin
            priority if (r_exposure < EXP_KNEE) begin
                w_mode = M_EXP_KNEE;
            end else if (r_gain < GAIN_KNEE) begin
                w_mode = M_GAIN_KNEE;
            end else if (r_exposure < i_cfg.max_exp) begin
                w_mode = M_EXP_MID;
            end else begin
                w_mode = M_GAIN_TOP;
            end
        end else if (w_light) begin
            w_mode = (r_gain > GAIN_DROP) ? M_GAIN_FLOOR : M_EXP_FAST;
        end else begin
            w_mode = M_NONE;
        end
    end

    // clamping of the scaled value
    assign w_v       = w_q20[V_W-1:0];
    assign w_ehi     = ext32((r_mode == M_EXP_KNEE) ? EXP_KNEE : i_cfg.max_exp);
    assign w_et      = (w_v > w_ehi) ? w_ehi : w_v;
    assign w_eclamp  = (w_et < ext32(i_cfg.min_exp)) ? ext32(i_cfg.min_exp) : w_et;
    assign w_exp_new = w_eclamp[15:0];

    always_comb begin
        unique case (r_mode)
            M_GAIN_KNEE:  w_g = (w_v > ext32(GAIN_KNEE)) ? ext32(GAIN_KNEE) : w_v;
            M_GAIN_TOP:   w_g = (w_v > ext32(i_cfg.gain_ceil)) ? ext32(i_cfg.gain_ceil) : w_v;
            M_GAIN_FLOOR: w_g = (w_v < ext32(GAIN_FLOOR)) ? ext32(GAIN_FLOOR) : w_v;
            default:      w_g = w_v;
        endcase
    end
    assign w_gain_new = sat_u16(w_g);

    // working registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_ctl.fire) begin
            if (i_ctl.mul_sel != MUL_NONE) begin
                r_prod <= w_prod;
            end
            unique case (i_ctl.op)
                OP_CAPTURE: begin
                    r_err    <= {1'b0, i_cfg.target} - {1'b0, i_mean_brightness};
                    r_bright <= i_mean_brightness;
                end
                OP_BAND:     r_adjusted <= !(w_mag < {1'b0, i_cfg.tolerance});
                OP_ADJ_LOAD: r_adj      <= r_prod[A_W-1:0];
                OP_ADJ_ADD:  r_adj      <= r_adj + r_prod[A_W-1:0];
                OP_PLAN:     r_mode     <= w_mode;
                OP_FACTOR:   r_factor   <= ONE_Q20 + w_q16[A_W-1:0];
                OP_OUT: begin
                    r_out_exp   <= r_exposure;
                    r_out_gain  <= r_gain;
                    r_out_noise <= r_noise;
                    r_out_adj   <= r_adjusted;
                end
                default: ;
            endcase
        end
    end

    // controller state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exposure  <= RST_EXPOSURE;
            r_gain      <= RST_GAIN;
            r_integ     <= '0;
            r_noise     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ctl.fire && (i_ctl.op == OP_PLAN)) begin
                r_integ <= w_integ_new;
            end
            if (i_ctl.fire && (i_ctl.op == OP_APPLY)) begin
                if (w_is_exp) begin
                    r_exposure <= w_exp_new;
                end else begin
                    r_gain <= w_gain_new;
                end
            end
            if (i_ctl.fire && (i_ctl.op == OP_FLAG)) begin
                r_noise <= (r_gain >= i_cfg.hi_gain_thr);
            end
            if (i_ctl.fire && (i_ctl.op == OP_OUT)) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.in_band  = w_mag < {1'b0, i_cfg.tolerance};
    assign o_stat.no_plan  = (r_mode == M_NONE);
    assign o_stat.out_busy = r_out_valid && i_out_stall;

    assign o_out_valid       = r_out_valid;
    assign o_exposure_time   = r_out_exp;
    assign o_analogue_gain   = r_out_gain;
    assign o_noise_reduction = r_out_noise;
    assign o_adjusted        = r_out_adj;

endmodule

`default_nettype wire

/* rtl/pi_auto_exposure_gain.sv */
// pi auto exposure and gain controller, top level
// ties together piaeg_cfg, piaeg_seq and piaeg_dp; uses piaeg_pkg and the assertion macros
//
// usage
//   input channel: one mean frame brightness (q8.8) per transaction on i_in_valid / o_in_stall
//   output channel: exposure, gain, noise flag and adjusted flag on o_out_valid / i_out_stall
//   config port: i_cfg_we writes i_cfg_data into register i_cfg_index; the user must write
//     only while no transaction is in flight, the block itself does not enforce it
//   the 12-step microprogram runs the shared multiplier in a separate step for each
//     product in the pi update, and a new transaction is taken only at its idle step
//   o_in_stall is high after the accept until the program returns to its idle step
//   the result sits in an output register, so a stalled result does not block the
//     computation; only the final step waits for the slot to free up
//   reset (synchronous, active low) loads the default registers, exposure 5000 us,
//     gain 2.0, zero integral, noise flag clear, and empties the output register
`timescale 1ns / 1ps
`default_nettype none
`include "pi_auto_exposure_gain_macros.svh"

module pi_auto_exposure_gain (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // brightness input channel
    input  wire                              i_in_valid,
    output logic                             o_in_stall,
    input  wire [15:0]                       i_mean_brightness,
    // result channel
    output logic                             o_out_valid,
    input  wire                              i_out_stall,
    output logic [15:0]                      o_exposure_time,
    output logic [15:0]                      o_analogue_gain,
    output logic                             o_noise_reduction,
    output logic                             o_adjusted,
    // configuration write port
    input  wire                              i_cfg_we,
    input  wire [piaeg_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire [15:0]                       i_cfg_data
);
    import piaeg_pkg::*;

    t_cfg     w_cfg;
    t_dp_ctl  w_ctl;
    t_dp_stat w_stat;
    logic     w_busy;

    // register bank; the user must write it only while idle, the block does not enforce it
    piaeg_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // step counter and program rom; takes branches on datapath status
    piaeg_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (w_stat),
        .o_ctl      (w_ctl),
        .o_busy     (w_busy)
    );

    // arithmetic, controller state and output register
    piaeg_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (w_cfg),
        .i_ctl             (w_ctl),
        .i_mean_brightness (i_mean_brightness),
        .i_out_stall       (i_out_stall),
        .o_stat            (w_stat),
        .o_out_valid       (o_out_valid),
        .o_exposure_time   (o_exposure_time),
        .o_analogue_gain   (o_analogue_gain),
        .o_noise_reduction (o_noise_reduction),
        .o_adjusted        (o_adjusted)
    );

    // input is taken only at the idle step
    assign o_in_stall = w_busy;

    // an accepted transaction always starts the program
    `PIAEG_ASSERT_NEXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall)
    // a new result only appears after the program has run
    `PIAEG_ASSERT_IMP(a_result_after_work, $rose(o_out_valid), $past(o_in_stall))
    // at the idle step the datapath does nothing but capture
    `PIAEG_ASSERT_IMP(a_idle_only_capture, !o_in_stall && w_ctl.fire, w_ctl.op == OP_CAPTURE)

endmodule

`default_nettype wire
